// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define WBPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner assertion failed");

// Next-cycle implication, off while reset is high.
`define WBPS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner assertion failed");

// Next-cycle implication, checked through reset too.
`define WBPS_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("scanner assertion failed");

`endif

// ===== rtl/core/wbps_pkg.sv =====
// Shared constants, types and compare function for the byte pattern scanner.
package wbps_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int PAT_BYTES   = 16;
   localparam int LEN_CAP     = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
   localparam int WIN_DEPTH   = MAX_PATTERN - 1;

   localparam int LEN_W  = 5;
   localparam int POS_W  = $clog2(PAT_BYTES);
   localparam int IDX_W  = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam int FILL_W = $clog2(WIN_DEPTH + 1);
   localparam int CMP_W  = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;

   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 32;
   localparam int REQ_DATA_W = 40;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_PAT_LO  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_PAT_HI  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_CARE    = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_PAT_LEN = 2'd3;

   // Pattern setup as seen by every cell; len is already clamped to 1..LEN_CAP.
   typedef struct packed {
      logic [PAT_BYTES-1:0][BYTE_W-1:0] pat;
      logic [PAT_BYTES-1:0]             care;
      logic [LEN_W-1:0]                 len;
   } pat_cfg_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] addr;
   } rsp_type;

   // One pattern position: wildcard or equal byte.
   function automatic logic pos_hit(input logic [BYTE_W-1:0] data,
                                    input logic [POS_W-1:0]  pos,
                                    input pat_cfg_type       cfg);
      pos_hit = !cfg.care[pos] || (data == cfg.pat[pos]);
   endfunction

endpackage

// ===== rtl/core/wildcard_byte_pattern_scanner_top.sv =====
// Top level of the wildcard byte pattern scanner: registers, cell row and result queue.
//
//   channel  dir  handshake        payload
//   req_     in   tvalid/tready    tdata = {byte_address, data_byte}, tlast = region_end
//   rsp_     out  tvalid/tready    tdata = match_address, tuser = found
//   csr_     in   APB, pready = 1  pattern low/high at 0x00/0x08, care 0x10, length 0x18
//
// One item per cycle while req_tready is high; each result is registered in the queue.
// The window is a row of byte cells that shift on every accepted item but a region's last,
// all compared at once.
// Reset is synchronous and needs no clearing pass; the block takes items the cycle after.
// Results wait in a two-entry queue; req_tready drops only while both entries are held.
module wildcard_byte_pattern_scanner_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] data_byte, [39:8] byte_address
   input  logic [wbps_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] match_address
   output logic [wbps_pkg::ADDR_W-1:0]       rsp_tdata,
   // [0] found
   output logic                              rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wbps_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [wbps_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   // configuration registers
   logic [63:0]                   pat_lo_ff;
   logic [63:0]                   pat_hi_ff;
   logic [15:0]                   care_ff;
   logic [wbps_pkg::LEN_W-1:0]    len_ff;
   logic                          csr_wr;
   logic [wbps_pkg::REG_IDX_W-1:0] csr_idx;

   // region state
   logic [wbps_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic                          reported_ff, reported_in;

   wbps_pkg::pat_cfg_type         cfg;
   logic [wbps_pkg::BYTE_W-1:0]   cur_byte;
   logic [wbps_pkg::ADDR_W-1:0]   cur_addr;
   logic                          accept;
   logic                          shift_en;
   logic [wbps_pkg::WIN_DEPTH-1:0] cell_hit;
   logic [wbps_pkg::WIN_DEPTH:0][wbps_pkg::BYTE_W-1:0] chain;
   logic                          cur_hit;
   logic                          any_care;
   logic                          fill_ok;
   logic                          match;
   logic                          push;
   logic                          q_not_full;
   wbps_pkg::rsp_type             push_data;
   wbps_pkg::rsp_type             q_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[wbps_pkg::CSR_ADDR_W-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
         care_ff   <= '0;
         len_ff    <= wbps_pkg::LEN_W'(1);
      end else if (csr_wr) begin
         unique case (csr_idx)
            wbps_pkg::REG_PAT_LO:  pat_lo_ff <= csr_pwdata;
            wbps_pkg::REG_PAT_HI:  pat_hi_ff <= csr_pwdata;
            wbps_pkg::REG_CARE:    care_ff   <= csr_pwdata[15:0];
            wbps_pkg::REG_PAT_LEN: len_ff    <= csr_pwdata[wbps_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         wbps_pkg::REG_PAT_LO:  csr_prdata = pat_lo_ff;
         wbps_pkg::REG_PAT_HI:  csr_prdata = pat_hi_ff;
         wbps_pkg::REG_CARE:    csr_prdata = 64'(care_ff);
         wbps_pkg::REG_PAT_LEN: csr_prdata = 64'(len_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // Pattern setup with the length clamped to 1..LEN_CAP.
   always_comb begin
      cfg.pat  = {pat_hi_ff, pat_lo_ff};
      cfg.care = care_ff;
      if (len_ff == '0) begin
         cfg.len = wbps_pkg::LEN_W'(1);
      end else if (len_ff > wbps_pkg::LEN_W'(wbps_pkg::LEN_CAP)) begin
         cfg.len = wbps_pkg::LEN_W'(wbps_pkg::LEN_CAP);
      end else begin
         cfg.len = len_ff;
      end
   end

   always_comb begin
      any_care = 1'b0;
      for (int i = 0; i < wbps_pkg::PAT_BYTES; i++) begin
         if (i < int'(cfg.len) && cfg.care[i]) begin
            any_care = 1'b1;
         end
      end
   end

   assign cur_byte = req_tdata[wbps_pkg::BYTE_W-1:0];
   assign cur_addr = req_tdata[wbps_pkg::BYTE_W +: wbps_pkg::ADDR_W];
   assign accept   = req_tvalid && req_tready;
   assign shift_en = accept && !req_tlast;
   assign chain[0] = cur_byte;

   genvar k;
   generate
      for (k = 0; k < wbps_pkg::WIN_DEPTH; k++) begin : g_cell
         wbps_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .cell_idx (wbps_pkg::IDX_W'(k)),
            .byte_in  (chain[k]),
            .cfg      (cfg),
            .byte_out (chain[k+1]),
            .hit      (cell_hit[k])
         );
      end
   endgenerate

   assign cur_hit = wbps_pkg::pos_hit(cur_byte,
                       wbps_pkg::POS_W'(cfg.len - wbps_pkg::LEN_W'(1)), cfg);
   assign fill_ok = wbps_pkg::CMP_W'(fill_ff) >= (wbps_pkg::CMP_W'(cfg.len) - wbps_pkg::CMP_W'(1));
   assign match   = !reported_ff && fill_ok && (&cell_hit) && cur_hit && any_care;

   always_comb begin
      push           = 1'b0;
      push_data      = '0;
      fill_in        = fill_ff;
      reported_in    = reported_ff;
      if (accept) begin
         if (req_tlast) begin
            push        = !reported_ff;
            fill_in     = '0;
            reported_in = 1'b0;
         end else begin
            push           = match;
            push_data.found = 1'b1;
            push_data.addr = cur_addr - wbps_pkg::ADDR_W'(cfg.len - wbps_pkg::LEN_W'(1));
            if (match) begin
               reported_in = 1'b1;
            end
            if (fill_ff != wbps_pkg::FILL_W'(wbps_pkg::WIN_DEPTH)) begin
               fill_in = fill_ff + wbps_pkg::FILL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         reported_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         reported_ff <= reported_in;
      end
   end

   wbps_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .not_full  (q_not_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (q_data)
   );

   assign req_tready = q_not_full;
   assign rsp_tdata  = q_data.addr;
   assign rsp_tuser  = q_data.found;

endmodule

// ===== rtl/core/wbps_cell.sv =====
// One window cell: holds an earlier byte, passes it on, and checks it against its position.
module wbps_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         shift_en,
   input  logic [wbps_pkg::IDX_W-1:0]   cell_idx,
   input  logic [wbps_pkg::BYTE_W-1:0]  byte_in,
   input  wbps_pkg::pat_cfg_type        cfg,
   output logic [wbps_pkg::BYTE_W-1:0]  byte_out,
   output logic                         hit
);

   logic [wbps_pkg::BYTE_W-1:0] win_ff;
   logic [wbps_pkg::BYTE_W-1:0] win_in;
   logic [wbps_pkg::CMP_W-1:0]  idx_w;
   logic [wbps_pkg::CMP_W-1:0]  len_w;
   logic [wbps_pkg::CMP_W-1:0]  pos_w;
   logic                        in_use;

   assign win_in = shift_en ? byte_in : win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   // Cell k holds the byte k+1 items back; it lines up with pattern position len-2-k.
   always_comb begin
      idx_w  = wbps_pkg::CMP_W'(cell_idx);
      len_w  = wbps_pkg::CMP_W'(cfg.len);
      in_use = (idx_w + wbps_pkg::CMP_W'(1)) < len_w;
      pos_w  = len_w - idx_w - wbps_pkg::CMP_W'(2);
      hit    = !in_use || wbps_pkg::pos_hit(win_ff, pos_w[wbps_pkg::POS_W-1:0], cfg);
   end

   assign byte_out = win_ff;

endmodule

// ===== rtl/core/wbps_rsp_queue.sv =====
// Two-entry result queue between the match logic and the result channel.
module wbps_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  wbps_pkg::rsp_type     push_data,
   output logic                  not_full,
   output logic                  out_valid,
   input  logic                  out_ready,
   output wbps_pkg::rsp_type     out_data
);

   wbps_pkg::rsp_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign not_full  = (count_ff != 2'd2);
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/wbps_checker.sv =====
// Port-level checks on the scanner top level, attached by bind.
`include "assert_macros.svh"

module wbps_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [wbps_pkg::ADDR_W-1:0]       rsp_tdata,
   input logic                              rsp_tuser
);

   // queue comes out of reset empty and open
   `WBPS_ASSERT_NXT_ALL(a_reset_empty, clock, reset, !rsp_tvalid && req_tready)
   // an empty queue never back-pressures the input
   `WBPS_ASSERT_IMP(a_empty_ready, clock, reset, !rsp_tvalid, req_tready)
   // a not-found result carries a zero address
   `WBPS_ASSERT_IMP(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   // a stalled result stays put until it is taken
   `WBPS_ASSERT_NXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind wildcard_byte_pattern_scanner_top wbps_checker u_wbps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
